>>> hdl/packet_protocol_statistics_defines.svh
// ----------------------------------------------------------------------------
// packet protocol statistics assertion macros
// shared assertion forms for the statistics block, clocked on the rising edge
// and held off while reset is asserted
// ----------------------------------------------------------------------------
`ifndef PACKET_PROTOCOL_STATISTICS_DEFINES_SVH
`define PACKET_PROTOCOL_STATISTICS_DEFINES_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ppstat_pkg.sv
// ----------------------------------------------------------------------------
// ppstat_pkg
// shared types and constants of the packet protocol statistics block
// ----------------------------------------------------------------------------
package ppstat_pkg;

    // fixed field widths
    localparam int TYPE_W   = 16;
    localparam int PROTO_W  = 8;
    localparam int FLEN_W   = 16;
    localparam int STAMP_W  = 64;
    localparam int TOTAL_W  = 64;

    // ip protocol table
    localparam int PROTO_ENTRIES = 256;
    localparam int PROTO_AW      = 8;

    // ethertype codes and register reset
    localparam logic [TYPE_W-1:0] LLC_LIMIT_RESET = 16'h05DC;
    localparam logic [TYPE_W-1:0] ETYPE_VLAN      = 16'h8100;
    localparam logic [TYPE_W-1:0] ETYPE_IPV4      = 16'h0800;
    localparam logic [TYPE_W-1:0] ETYPE_IPV6      = 16'h86DD;

    // request codes on the input side
    typedef enum logic [1:0] {
        REQ_FRAME   = 2'd0,
        REQ_SUMMARY = 2'd1,
        REQ_TYPE    = 2'd2,
        REQ_PROTO   = 2'd3
    } req_kind_t;

    // result codes on the output side
    typedef enum logic [1:0] {
        KIND_SUMMARY = 2'd0,
        KIND_TYPE    = 2'd1,
        KIND_PROTO   = 2'd2
    } read_kind_t;

    // classified item passed from front to back
    typedef struct packed {
        req_kind_t            req;
        logic [FLEN_W-1:0]    len;
        logic [STAMP_W-1:0]   stamp;
        logic [TYPE_W-1:0]    type_idx;
        logic [PROTO_W-1:0]   proto_idx;
        logic                 type_hit;
        logic                 proto_hit;
    } work_item_t;

    // result payload, first member in the top bits
    typedef struct packed {
        logic [STAMP_W-1:0]   last_seen;
        logic [STAMP_W-1:0]   first_seen;
        logic [FLEN_W-1:0]    longest;
        logic [FLEN_W-1:0]    shortest;
        logic [TOTAL_W-1:0]   byte_total;
        logic [TOTAL_W-1:0]   packet_total;
    } result_t;

endpackage

>>> hdl/ppstat_fifo.sv
// ----------------------------------------------------------------------------
// ppstat_fifo
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module ppstat_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  ppstat_pkg::work_item_t  push_item,
    output logic                    full,
    input  logic                    pop,
    output logic                    not_empty,
    output ppstat_pkg::work_item_t  head_item
);

    ppstat_pkg::work_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_item = entry_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/ppstat_front.sv
// ----------------------------------------------------------------------------
// ppstat_front
// accepts input beats, holds the llc limit register and classifies each item
// ----------------------------------------------------------------------------
module ppstat_front #(
    parameter int TYPE_ENTRIES = 65536,
    parameter int LEN_WIDTH    = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration write
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [15:0]             cfg_data,
    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [1:0]              s_tuser,
    input  logic [119:0]            s_tdata,
    // toward the queue
    input  logic                    fifo_full,
    input  logic                    clearing,
    output logic                    push,
    output ppstat_pkg::work_item_t  push_item
);

    localparam logic [ppstat_pkg::FLEN_W-1:0] LEN_MASK =
        ppstat_pkg::FLEN_W'((32'd1 << LEN_WIDTH) - 32'd1);

    logic [ppstat_pkg::TYPE_W-1:0]  llc_max_reg;
    logic [ppstat_pkg::TYPE_W-1:0]  llc_max_next;
    logic [ppstat_pkg::FLEN_W-1:0]  frame_len;
    logic [ppstat_pkg::TYPE_W-1:0]  ether_type;
    logic [ppstat_pkg::PROTO_W-1:0] ip_proto;
    logic [ppstat_pkg::STAMP_W-1:0] time_stamp;
    logic [15:0]                    read_index;
    ppstat_pkg::req_kind_t          req;
    logic                           above_llc;
    logic                           ip_carrier;

    // unpack the beat
    assign req        = ppstat_pkg::req_kind_t'(s_tuser);
    assign frame_len  = s_tdata[15:0];
    assign ether_type = s_tdata[31:16];
    assign ip_proto   = s_tdata[39:32];
    assign time_stamp = s_tdata[103:40];
    assign read_index = s_tdata[119:104];

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = !fifo_full && !clearing;
    assign push      = s_tvalid && s_tready;

    // llc limit register
    always_comb begin
        llc_max_next = llc_max_reg;
        if (cfg_valid && cfg_ready) begin
            llc_max_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            llc_max_reg <= ppstat_pkg::LLC_LIMIT_RESET;
        end else begin
            llc_max_reg <= llc_max_next;
        end
    end

    // classify the item
    assign above_llc  = (ether_type > llc_max_reg);
    assign ip_carrier = (ether_type == ppstat_pkg::ETYPE_VLAN) ||
                        (ether_type == ppstat_pkg::ETYPE_IPV4);

    always_comb begin
        push_item.req       = req;
        push_item.len       = frame_len & LEN_MASK;
        push_item.stamp     = time_stamp;
        push_item.type_idx  = ether_type;
        push_item.proto_idx = ip_proto;
        push_item.type_hit  = above_llc && (32'(ether_type) < TYPE_ENTRIES);
        push_item.proto_hit = above_llc && ip_carrier;
        if (req != ppstat_pkg::REQ_FRAME) begin
            push_item.type_idx  = read_index;
            push_item.proto_idx = read_index[ppstat_pkg::PROTO_W-1:0];
            push_item.type_hit  = (32'(read_index) < TYPE_ENTRIES);
            push_item.proto_hit = (32'(read_index) < ppstat_pkg::PROTO_ENTRIES);
        end
    end

endmodule

>>> hdl/ppstat_back.sv
// ----------------------------------------------------------------------------
// ppstat_back
// clears the counter tables, runs counter read-modify-write for frames and
// answers read requests through a registered output beat
// ----------------------------------------------------------------------------
`include "packet_protocol_statistics_defines.svh"

module ppstat_back #(
    parameter int TYPE_ENTRIES = 65536,
    parameter int COUNT_WIDTH  = 64,
    parameter int LEN_WIDTH    = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // from the queue
    input  logic                    fifo_valid,
    input  ppstat_pkg::work_item_t  fifo_item,
    output logic                    pop,
    output logic                    clearing,
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [1:0]              m_tuser,
    output logic [287:0]            m_tdata
);

    localparam int TYPE_AW  = $clog2(TYPE_ENTRIES);
    localparam int PROTO_AW = ppstat_pkg::PROTO_AW;
    localparam int ENTRY_W  = 2 * COUNT_WIDTH;
    localparam logic [TYPE_AW-1:0]   CLEAR_LAST = TYPE_AW'(TYPE_ENTRIES - 1);
    localparam logic [LEN_WIDTH-1:0] LEN_ONES   = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // counter tables, packets in the low half, bytes in the high half
    logic [ENTRY_W-1:0] type_mem  [TYPE_ENTRIES];
    logic [ENTRY_W-1:0] proto_mem [ppstat_pkg::PROTO_ENTRIES];

    logic [ENTRY_W-1:0]  type_rd_reg;
    logic [ENTRY_W-1:0]  proto_rd_reg;
    logic                rd_en;
    logic                type_we;
    logic [TYPE_AW-1:0]  type_wa;
    logic [ENTRY_W-1:0]  type_wd;
    logic                proto_we;
    logic [PROTO_AW-1:0] proto_wa;
    logic [ENTRY_W-1:0]  proto_wd;

    state_t                          state_reg,  state_next;
    logic [TYPE_AW-1:0]              clr_cnt_reg, clr_cnt_next;
    ppstat_pkg::work_item_t          cur_reg,    cur_next;
    logic [COUNT_WIDTH-1:0]          frames_reg, frames_next;
    logic [COUNT_WIDTH-1:0]          bytes_reg,  bytes_next;
    logic [LEN_WIDTH-1:0]            min_len_reg, min_len_next;
    logic [LEN_WIDTH-1:0]            max_len_reg, max_len_next;
    logic [ppstat_pkg::STAMP_W-1:0]  first_reg,  first_next;
    logic [ppstat_pkg::STAMP_W-1:0]  last_reg,   last_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    ppstat_pkg::read_kind_t          m_kind_reg, m_kind_next;
    ppstat_pkg::result_t             m_data_reg, m_data_next;

    logic [LEN_WIDTH-1:0]   cur_len;
    logic [COUNT_WIDTH-1:0] len_ext;
    logic [COUNT_WIDTH-1:0] type_pk;
    logic [COUNT_WIDTH-1:0] type_by;
    logic [COUNT_WIDTH-1:0] proto_pk;
    logic [COUNT_WIDTH-1:0] proto_by;
    logic                   out_free;
    logic                   is_frame;
    ppstat_pkg::result_t    result;
    ppstat_pkg::read_kind_t result_kind;

    assign cur_len  = cur_reg.len[LEN_WIDTH-1:0];
    assign len_ext  = COUNT_WIDTH'(cur_len);
    assign type_pk  = type_rd_reg[COUNT_WIDTH-1:0];
    assign type_by  = type_rd_reg[ENTRY_W-1:COUNT_WIDTH];
    assign proto_pk = proto_rd_reg[COUNT_WIDTH-1:0];
    assign proto_by = proto_rd_reg[ENTRY_W-1:COUNT_WIDTH];
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_frame = (cur_reg.req == ppstat_pkg::REQ_FRAME);

    assign clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_data_reg;

    // table ports: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (type_we) begin
            type_mem[type_wa] <= type_wd;
        end
        if (rd_en) begin
            type_rd_reg <= type_mem[fifo_item.type_idx[TYPE_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (proto_we) begin
            proto_mem[proto_wa] <= proto_wd;
        end
        if (rd_en) begin
            proto_rd_reg <= proto_mem[fifo_item.proto_idx];
        end
    end

    // table write-back, clearing sweep or counter increment
    always_comb begin
        type_we  = 1'b0;
        type_wa  = cur_reg.type_idx[TYPE_AW-1:0];
        type_wd  = {type_by + len_ext, type_pk + COUNT_WIDTH'(1)};
        proto_we = 1'b0;
        proto_wa = cur_reg.proto_idx;
        proto_wd = {proto_by + len_ext, proto_pk + COUNT_WIDTH'(1)};
        if (state_reg == ST_CLEAR) begin
            type_we  = 1'b1;
            type_wa  = clr_cnt_reg;
            type_wd  = '0;
            proto_we = (32'(clr_cnt_reg) < ppstat_pkg::PROTO_ENTRIES);
            proto_wa = clr_cnt_reg[PROTO_AW-1:0];
            proto_wd = '0;
        end else if (state_reg == ST_EXEC && is_frame) begin
            type_we  = cur_reg.type_hit;
            proto_we = cur_reg.proto_hit;
        end
    end

    // result of a read request
    always_comb begin
        result      = '0;
        result_kind = ppstat_pkg::KIND_SUMMARY;
        case (cur_reg.req)
            ppstat_pkg::REQ_SUMMARY: begin
                result.packet_total = ppstat_pkg::TOTAL_W'(frames_reg);
                result.byte_total   = ppstat_pkg::TOTAL_W'(bytes_reg);
                if (frames_reg != '0) begin
                    result.shortest = ppstat_pkg::FLEN_W'(min_len_reg);
                    result.longest  = ppstat_pkg::FLEN_W'(max_len_reg);
                end
                result.first_seen = first_reg;
                result.last_seen  = last_reg;
            end
            ppstat_pkg::REQ_TYPE: begin
                result_kind = ppstat_pkg::KIND_TYPE;
                if (cur_reg.type_hit) begin
                    result.packet_total = ppstat_pkg::TOTAL_W'(type_pk);
                    result.byte_total   = ppstat_pkg::TOTAL_W'(type_by);
                end
            end
            ppstat_pkg::REQ_PROTO: begin
                result_kind = ppstat_pkg::KIND_PROTO;
                if (cur_reg.proto_hit) begin
                    result.packet_total = ppstat_pkg::TOTAL_W'(proto_pk);
                    result.byte_total   = ppstat_pkg::TOTAL_W'(proto_by);
                end
            end
            default: begin
                result_kind = ppstat_pkg::KIND_SUMMARY;
            end
        endcase
    end

    // sequencer: clear sweep, fetch, execute
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cur_next      = cur_reg;
        frames_next   = frames_reg;
        bytes_next    = bytes_reg;
        min_len_next  = min_len_reg;
        max_len_next  = max_len_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_data_next   = m_data_reg;
        pop           = 1'b0;
        rd_en         = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + TYPE_AW'(1);
                if (clr_cnt_reg == CLEAR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (fifo_valid) begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    cur_next   = fifo_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (is_frame) begin
                    frames_next = frames_reg + COUNT_WIDTH'(1);
                    bytes_next  = bytes_reg + len_ext;
                    last_next   = cur_reg.stamp;
                    if (frames_next == COUNT_WIDTH'(1)) begin
                        first_next = cur_reg.stamp;
                    end
                    if (cur_len < min_len_reg) begin
                        min_len_next = cur_len;
                    end
                    if (cur_len > max_len_reg) begin
                        max_len_next = cur_len;
                    end
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = result_kind;
                    m_data_next   = result;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_kind_reg <= m_kind_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            frames_reg   <= '0;
            bytes_reg    <= '0;
            min_len_reg  <= LEN_ONES;
            max_len_reg  <= '0;
            first_reg    <= '0;
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            frames_reg   <= frames_next;
            bytes_reg    <= bytes_next;
            min_len_reg  <= min_len_next;
            max_len_reg  <= max_len_next;
            first_reg    <= first_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // checks on the sequencer
    `PPS_ASSERT_NOW(a_no_result_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !m_tvalid_reg, "result during clear")
    `PPS_ASSERT_NOW(a_pop_only_idle, aclk, aresetn, pop, state_reg == ST_IDLE && fifo_valid, "pop outside fetch")
    `PPS_ASSERT_NEXT(a_frame_one_exec, aclk, aresetn, state_reg == ST_EXEC && is_frame, state_reg == ST_IDLE, "frame exec stalled")
    `PPS_ASSERT_NEXT(a_frame_counts, aclk, aresetn, state_reg == ST_EXEC && is_frame, frames_reg == COUNT_WIDTH'($past(frames_reg) + COUNT_WIDTH'(1)), "frame count missed")
    `PPS_ASSERT_NOW(a_result_from_exec, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == ST_EXEC, "result not from exec")

endmodule

>>> hdl/packet_protocol_statistics.sv
// ----------------------------------------------------------------------------
// packet_protocol_statistics
// per-ethertype and per-ip-protocol packet and byte counters with a summary
// ----------------------------------------------------------------------------
// Each input beat is one captured frame or one read request. The counter
// engine first reads the ethertype and protocol counter memories, then
// writes the incremented counts back (or loads the result register for a
// read), and takes no new item until the current one is done. A two-entry
// queue sits between the input side and the engine, and the result sits in
// an output register, so new beats are taken while a result waits. After
// reset the engine clears both counter memories in a sweep over all
// TYPE_ENTRIES addresses; s_tready stays low for that time, while the llc
// limit register can be written at any time.
module packet_protocol_statistics #(
    parameter int TYPE_ENTRIES = 65536,
    parameter int COUNT_WIDTH  = 64,
    parameter int LEN_WIDTH    = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    // llc limit register write
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data,
    // input stream
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [1:0]     s_tuser,   // req_type
    input  logic [119:0]   s_tdata,   // frame_len, ether_type, ip_proto, time_stamp, read_index
    // result stream
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [1:0]     m_tuser,   // read_kind
    output logic [287:0]   m_tdata    // packet_total, byte_total, shortest, longest,
                                      // first_seen, last_seen
);

    logic                   fifo_full;
    logic                   fifo_valid;
    logic                   clearing;
    logic                   push;
    logic                   pop;
    ppstat_pkg::work_item_t push_item;
    ppstat_pkg::work_item_t head_item;

    // input side
    ppstat_front #(
        .TYPE_ENTRIES (TYPE_ENTRIES),
        .LEN_WIDTH    (LEN_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .fifo_full (fifo_full),
        .clearing  (clearing),
        .push      (push),
        .push_item (push_item)
    );

    // item queue
    ppstat_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_valid),
        .head_item (head_item)
    );

    // counter engine
    ppstat_back #(
        .TYPE_ENTRIES (TYPE_ENTRIES),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .LEN_WIDTH    (LEN_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_valid (fifo_valid),
        .fifo_item  (head_item),
        .pop        (pop),
        .clearing   (clearing),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata)
    );

endmodule
